[src/kps_pkg.sv]
// Shared types and constants for the two-axis position smoother.
// Used by kps_div, kps_lane and kalman_position_smoother; no dependencies.
package kps_pkg;

  localparam int unsigned VarW   = 32;  // variance and predicted variance
  localparam int unsigned RegW   = 31;  // configuration registers and gain
  localparam int unsigned EstW   = 32;  // Q16.16 estimates
  localparam int unsigned PosW   = 16;  // integer pixel measurements
  localparam int unsigned FracW  = 30;  // fraction bits of variances and gain
  localparam int unsigned CfgIdxW = 2;

  localparam logic [RegW-1:0] ONE_Q30 = RegW'(1) << FracW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MEASURE_NOISE    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_INITIAL_VARIANCE = 2'd2;

  localparam logic [RegW-1:0] PROCESS_NOISE_RST    = 31'd107374;
  localparam logic [RegW-1:0] MEASURE_NOISE_RST    = 31'd107374182;
  localparam logic [RegW-1:0] INITIAL_VARIANCE_RST = 31'd107374182;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
  } in_t;

  typedef struct packed {
    logic signed [EstW-1:0] est_x;
    logic signed [EstW-1:0] est_y;
    logic [RegW-1:0]        gain;
  } out_t;

  // Per-lane strobes from the sequencer
  typedef struct packed {
    logic load;    // capture measurement residual
    logic mult;    // form gain * |residual|
    logic update;  // commit the new estimate
  } lane_ctrl_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_PUSH = 6'b100000
  } state_t;

endpackage

[src/kps_div.sv]
// Radix-2 restoring divider for the gain: quot = floor(pp * 2^30 / den) for pp < 2 * den.
// Depends on kps_pkg for widths.
module kps_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [kps_pkg::VarW-1:0]    pp,
  input  logic [kps_pkg::VarW:0]      den,
  output logic                        done,
  output logic [kps_pkg::RegW-1:0]    quot
);

  localparam int unsigned CntW = $clog2(kps_pkg::FracW);

  logic                         busy;
  logic [CntW-1:0]              cnt;
  logic [kps_pkg::VarW:0]       den_r;
  logic [kps_pkg::VarW:0]       rem;
  logic [kps_pkg::FracW-1:0]    frac;
  logic                         ibit;
  logic                         zero;
  logic [kps_pkg::VarW+1:0]     rem_sh;
  logic                         take;
  logic [kps_pkg::VarW:0]       pp_ext;

  assign pp_ext = {1'b0, pp};
  assign rem_sh = {rem, 1'b0};
  assign take   = rem_sh >= {1'b0, den_r};
  assign quot   = zero ? '0 : {ibit, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(kps_pkg::FracW - 1);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: integer bit first, then one fraction bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      zero  <= (den == '0);
      frac  <= '0;
      if (pp_ext >= den) begin
        ibit <= 1'b1;
        rem  <= pp_ext - den;
      end else begin
        ibit <= 1'b0;
        rem  <= pp_ext;
      end
    end else if (busy) begin
      frac <= {frac[kps_pkg::FracW-2:0], take};
      if (take) begin
        rem <= rem_sh[kps_pkg::VarW:0] - den_r;
      end else begin
        rem <= rem_sh[kps_pkg::VarW:0];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  assert property (@(posedge clk) disable iff (rst) (busy && !zero) |-> rem < den_r)
    else $error("divider remainder out of range");

endmodule

[src/kps_lane.sv]
// One axis lane: holds the estimate and moves it toward the measurement by gain.
// Depends on kps_pkg for widths and the lane strobe struct.
module kps_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  kps_pkg::lane_ctrl_t                ctrl,
  input  logic signed [kps_pkg::PosW-1:0]    meas,
  input  logic [kps_pkg::RegW-1:0]           gain,
  output logic signed [kps_pkg::EstW-1:0]    est
);

  localparam int unsigned ProdW = kps_pkg::EstW + kps_pkg::RegW;

  logic signed [kps_pkg::EstW:0] meas_q;
  logic signed [kps_pkg::EstW:0] diff;
  logic [kps_pkg::EstW:0]        diff_abs;
  logic                          neg;
  logic [kps_pkg::EstW-1:0]      mag;
  logic [ProdW-1:0]              prod;
  logic [kps_pkg::EstW-1:0]      step;

  assign meas_q   = {meas[kps_pkg::PosW-1], meas, 16'b0};
  assign diff     = meas_q - {est[kps_pkg::EstW-1], est};
  assign diff_abs = diff[kps_pkg::EstW] ? (~diff + 1'b1) : diff;
  assign step     = prod[kps_pkg::FracW +: kps_pkg::EstW];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg <= diff[kps_pkg::EstW];
      mag <= diff_abs[kps_pkg::EstW-1:0];
    end
    if (ctrl.mult) begin
      prod <= {{(ProdW-kps_pkg::EstW){1'b0}}, mag}
            * {{(ProdW-kps_pkg::RegW){1'b0}}, gain};
    end
  end

  // Truncate the step toward zero, then advance
  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
    end else if (ctrl.update) begin
      est <= neg ? est - step : est + step;
    end
  end

endmodule

[src/kalman_position_smoother.sv]
// Top level of the two-axis constant-position smoother: sequencer, variance path,
// output register. Depends on kps_pkg, kps_div and kps_lane.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one measured position
//   (pos_x, pos_y in integer pixels). Output channel out_valid / out_stall /
//   out_data carries one result per transaction: est_x, est_y in Q16.16 and the
//   gain used, 30 fraction bits. A transaction completes when valid is high
//   and stall is low.
//   After an input transaction the sequencer runs setup, the 30-step
//   bit-serial gain divider, gain capture, multiply, estimate update and output
//   load in that order. A new item is taken only once the sequencer is idle
//   again, after the previous result has been loaded into the output register.
//   in_stall is low only while the sequencer is idle. A finished result waits
//   in the output register while the receiver stalls; the next item is still
//   accepted and worked on, and its result is held until the register frees.
//   Reset clears both estimates, reloads the register defaults and sets the
//   variance to initial_variance. Configuration writes (cfg_we, cfg_index,
//   cfg_data) are registered; writing initial_variance also reloads the
//   variance. Write only while no transaction is in flight.
module kalman_position_smoother (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kps_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kps_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [kps_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [kps_pkg::RegW-1:0]       cfg_data
);

  localparam int unsigned VProdW = kps_pkg::VarW + kps_pkg::RegW;

  kps_pkg::state_t            state;
  kps_pkg::state_t            state_next;
  kps_pkg::lane_ctrl_t        lane_ctrl;

  logic [kps_pkg::RegW-1:0]   process_noise;
  logic [kps_pkg::RegW-1:0]   measure_noise;
  logic [kps_pkg::VarW-1:0]   variance;

  logic [kps_pkg::VarW-1:0]   pp;
  logic [kps_pkg::VarW:0]     pp_sum;
  logic [kps_pkg::VarW-1:0]   pp_sat;
  logic [kps_pkg::VarW:0]     den;
  logic [kps_pkg::RegW-1:0]   gain;
  logic [VProdW-1:0]          vprod;

  logic                       in_take;
  logic                       out_free;
  logic                       div_done;
  logic [kps_pkg::RegW-1:0]   div_quot;
  logic signed [kps_pkg::EstW-1:0] est_x;
  logic signed [kps_pkg::EstW-1:0] est_y;

  assign in_stall = (state != kps_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Predicted variance, saturated to 32 bits
  assign pp_sum = {1'b0, variance} + {2'b0, process_noise};
  assign pp_sat = pp_sum[kps_pkg::VarW] ? '1 : pp_sum[kps_pkg::VarW-1:0];
  assign den    = {1'b0, pp} + {2'b0, measure_noise};

  assign lane_ctrl.load   = in_take;
  assign lane_ctrl.mult   = (state == kps_pkg::ST_MUL);
  assign lane_ctrl.update = (state == kps_pkg::ST_UPD);

  always_comb begin
    state_next = state;
    case (state)
      kps_pkg::ST_IDLE: if (in_take) state_next = kps_pkg::ST_LOAD;
      kps_pkg::ST_LOAD: state_next = kps_pkg::ST_DIV;
      kps_pkg::ST_DIV:  if (div_done) state_next = kps_pkg::ST_MUL;
      kps_pkg::ST_MUL:  state_next = kps_pkg::ST_UPD;
      kps_pkg::ST_UPD:  state_next = kps_pkg::ST_PUSH;
      kps_pkg::ST_PUSH: if (out_free) state_next = kps_pkg::ST_IDLE;
      default:          state_next = kps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers and the variance state
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise    <= kps_pkg::PROCESS_NOISE_RST;
      measure_noise    <= kps_pkg::MEASURE_NOISE_RST;
      variance         <= {1'b0, kps_pkg::INITIAL_VARIANCE_RST};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kps_pkg::REG_PROCESS_NOISE:  process_noise <= cfg_data;
          kps_pkg::REG_MEASURE_NOISE:  measure_noise <= cfg_data;
          // Only the variance needs this value; there is no read-back
          kps_pkg::REG_INITIAL_VARIANCE: variance <= {1'b0, cfg_data};
          default: ;  // drop writes beyond the register list
        endcase
      end else if (state == kps_pkg::ST_UPD) begin
        // (1 - g) * pp, keep the integer part above the 30 fraction bits
        variance <= vprod[kps_pkg::FracW +: kps_pkg::VarW];
      end
    end
  end

  // Gain datapath: hold pp for the divider, capture the quotient, scale variance
  always_ff @(posedge clk) begin
    if (in_take) begin
      pp <= pp_sat;
    end
    if ((state == kps_pkg::ST_DIV) && div_done) begin
      gain <= div_quot;
    end
    if (state == kps_pkg::ST_MUL) begin
      vprod <= {{(VProdW-kps_pkg::RegW){1'b0}}, kps_pkg::ONE_Q30 - gain}
             * {{(VProdW-kps_pkg::VarW){1'b0}}, pp};
    end
  end

  kps_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == kps_pkg::ST_LOAD),
    .pp    (pp),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  kps_lane u_lane_x (
    .clk  (clk),
    .rst  (rst),
    .ctrl (lane_ctrl),
    .meas (in_data.pos_x),
    .gain (gain),
    .est  (est_x)
  );

  kps_lane u_lane_y (
    .clk  (clk),
    .rst  (rst),
    .ctrl (lane_ctrl),
    .meas (in_data.pos_y),
    .gain (gain),
    .est  (est_y)
  );

  // Merge the lanes and the gain into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == kps_pkg::ST_PUSH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == kps_pkg::ST_PUSH) && out_free) begin
      out_data.est_x <= est_x;
      out_data.est_y <= est_y;
      out_data.gain  <= gain;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      div_done |-> (state == kps_pkg::ST_DIV))
    else $error("gain divider finished outside the divide phase");
  assert property (@(posedge clk) disable iff (rst)
      (state == kps_pkg::ST_MUL) |-> (gain <= kps_pkg::ONE_Q30))
    else $error("gain above one");
  assert property (@(posedge clk) disable iff (rst)
      ((state == kps_pkg::ST_UPD) && !cfg_we) |=> (variance <= pp))
    else $error("updated variance exceeds predicted variance");
  assert property (@(posedge clk) disable iff (rst)
      ((state == kps_pkg::ST_PUSH) && out_valid && out_stall) |=> (state == kps_pkg::ST_PUSH))
    else $error("result dropped while the output register was full");

endmodule
